@@ rtl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants for the ordered list engine
// Holds the store depth, the field widths and the command and status codes.
// ----------------------------------------------------------------------------
package ole_pkg;

  // Store geometry
  localparam int DEPTH    = 64;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW       = $clog2(DEPTH + 1);

  // Field widths of the item channels
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int FOUND_W  = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Width that holds both a position and a count for compares
  localparam int CMPW     = (CW > POS_W) ? CW + 1 : POS_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_REVERSE   = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

@@ rtl/ole_if.sv @@
// ----------------------------------------------------------------------------
// ole_if: item channels of the ordered list engine
// Request channel carries one operation, response channel one result.
// ----------------------------------------------------------------------------
interface ole_req_if;
  import ole_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface ole_rsp_if;
  import ole_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  removed_value;
  logic [FOUND_W-1:0]         found_index;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         entry_count;

  modport source (output valid, removed_value, found_index, status, entry_count,
                  input ready);
  modport sink   (input valid, removed_value, found_index, status, entry_count,
                  output ready);
endinterface

@@ rtl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed values with a shift sequencer
// Insert and delete shift the tail of the list by one, search scans from
// the front and reverse swaps pairs from both ends inward. An item is taken
// only in idle, so a new item waits until the last result is loaded into
// the output register. Reset empties the list at once; the store contents
// are left as they are.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic      clk,
  input  logic      rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_MV,
    S_INS_PUT,
    S_DEL_MV,
    S_SRCH,
    S_REV_W1,
    S_REV_W2,
    S_FIN
  } state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             hi;
  logic [AW-1:0]             at;
  logic                      first;
  logic [VALUE_W-1:0]        val;
  logic [VALUE_W-1:0]        removed;
  logic [AW-1:0]             found;
  status_t                   status;

  // Output register
  logic                      out_valid;
  logic [VALUE_W-1:0]        out_removed;
  logic [FOUND_W-1:0]        out_found;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;

  // Store and its ports
  logic [VALUE_W-1:0]        mem [DEPTH];
  logic [VALUE_W-1:0]        rd_a;
  logic [VALUE_W-1:0]        rd_b;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [VALUE_W-1:0]        wd;
  logic                      re_a;
  logic [AW-1:0]             ra;
  logic                      re_b;
  logic [AW-1:0]             rb;

  logic                      acc;
  cmd_t                      cmd;
  logic [CMPW-1:0]           cnt_x;
  logic [CMPW-1:0]           pos_x;
  logic [CMPW-1:0]           ins_at_x;
  logic [CMPW-1:0]           del_at_x;
  logic                      ins_bad;
  logic                      ins_full;
  logic                      del_bad;
  logic                      idx_more;
  logic                      rev_more;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign cmd       = cmd_t'(req.cmd);

  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_removed;
  assign rsp.found_index   = out_found;
  assign rsp.status        = out_status;
  assign rsp.entry_count   = out_count;

  // Decode the target position and the checks of a new item
  assign cnt_x = CMPW'(count);
  assign pos_x = CMPW'(req.position);

  always_comb begin
    case (cmd)
      CMD_INS_FRONT: ins_at_x = '0;
      CMD_INS_BACK:  ins_at_x = cnt_x;
      default:       ins_at_x = pos_x;
    endcase
    case (cmd)
      CMD_DEL_FRONT: del_at_x = '0;
      CMD_DEL_BACK:  del_at_x = cnt_x - CMPW'(1);
      default:       del_at_x = pos_x;
    endcase
  end

  assign ins_bad  = ins_at_x > cnt_x;
  assign ins_full = cnt_x >= CMPW'(DEPTH);
  assign del_bad  = del_at_x >= cnt_x;
  assign idx_more = (CW'(idx) + CW'(1)) < count;
  assign rev_more = ({1'b0, idx} + (AW+1)'(2)) < {1'b0, hi};

  // Memory access per sequencer step
  always_comb begin
    we   = 1'b0;
    wa   = idx;
    wd   = rd_a;
    re_a = 1'b0;
    ra   = idx;
    re_b = 1'b0;
    rb   = hi;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
              if (!ins_bad && !ins_full && (cnt_x > ins_at_x)) begin
                re_a = 1'b1;
                ra   = AW'(count - CW'(1));
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
              if ((count != '0) && !del_bad) begin
                re_a = 1'b1;
                ra   = AW'(del_at_x);
              end
            end
            CMD_SEARCH: begin
              re_a = (count != '0);
              ra   = '0;
            end
            default: begin
              re_a = (count > CW'(1));
              ra   = '0;
              re_b = (count > CW'(1));
              rb   = AW'(count - CW'(1));
            end
          endcase
        end
      end
      S_INS_MV: begin
        we = 1'b1;
        wa = idx + AW'(1);
        wd = rd_a;
        if (idx > at) begin
          re_a = 1'b1;
          ra   = idx - AW'(1);
        end
      end
      S_INS_PUT: begin
        we = 1'b1;
        wa = at;
        wd = val;
      end
      S_DEL_MV: begin
        we = !first;
        wa = idx - AW'(1);
        wd = rd_a;
        re_a = idx_more;
        ra   = idx + AW'(1);
      end
      S_SRCH: begin
        re_a = (rd_a != val) && idx_more;
        ra   = idx + AW'(1);
      end
      S_REV_W1: begin
        we = 1'b1;
        wa = idx;
        wd = rd_b;
      end
      S_REV_W2: begin
        we   = 1'b1;
        wa   = hi;
        wd   = rd_a;
        re_a = rev_more;
        ra   = idx + AW'(1);
        re_b = rev_more;
        rb   = hi - AW'(1);
      end
      default: ;
    endcase
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a <= mem[ra];
    end
    if (re_b) begin
      rd_b <= mem[rb];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Release the output register once the result is taken
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            val     <= req.value;
            removed <= '0;
            found   <= '0;
            status  <= ST_OK;
            first   <= 1'b1;
            case (cmd)
              CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (ins_bad) begin
                  status <= ST_BADPOS;
                  state  <= S_FIN;
                end else if (ins_full) begin
                  status <= ST_FULL;
                  state  <= S_FIN;
                end else begin
                  at <= AW'(ins_at_x);
                  if (cnt_x > ins_at_x) begin
                    idx   <= AW'(count - CW'(1));
                    state <= S_INS_MV;
                  end else begin
                    state <= S_INS_PUT;
                  end
                end
              end
              CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_FIN;
                end else if (del_bad) begin
                  status <= ST_BADPOS;
                  state  <= S_FIN;
                end else begin
                  idx   <= AW'(del_at_x);
                  state <= S_DEL_MV;
                end
              end
              CMD_SEARCH: begin
                idx <= '0;
                if (count == '0) begin
                  status <= ST_NOTFOUND;
                  state  <= S_FIN;
                end else begin
                  state <= S_SRCH;
                end
              end
              default: begin
                idx <= '0;
                hi  <= AW'(count - CW'(1));
                if (count > CW'(1)) begin
                  state <= S_REV_W1;
                end else begin
                  state <= S_FIN;
                end
              end
            endcase
          end
        end
        // Move entries up by one, last first, then drop the value in
        S_INS_MV: begin
          if (idx > at) begin
            idx <= idx - AW'(1);
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        // Take out the entry, then move the tail down by one
        S_DEL_MV: begin
          first <= 1'b0;
          if (first) begin
            removed <= rd_a;
          end
          if (idx_more) begin
            idx <= idx + AW'(1);
          end else begin
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end
        // Scan from the front for the first match
        S_SRCH: begin
          if (rd_a == val) begin
            found <= idx;
            state <= S_FIN;
          end else if (idx_more) begin
            idx <= idx + AW'(1);
          end else begin
            status <= ST_NOTFOUND;
            state  <= S_FIN;
          end
        end
        // Swap the outer pair, then step inward
        S_REV_W1: begin
          state <= S_REV_W2;
        end
        S_REV_W2: begin
          if (rev_more) begin
            idx   <= idx + AW'(1);
            hi    <= hi - AW'(1);
            state <= S_REV_W1;
          end else begin
            state <= S_FIN;
          end
        end
        // Hand the result over once the output register is free
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_removed <= removed;
            out_found   <= FOUND_W'(found);
            out_status  <= status;
            out_count   <= COUNT_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/ole_checker.sv @@
// ----------------------------------------------------------------------------
// ole_checker: port-level checks for the ordered list engine
// Watches the item channels and flags results that break the list rules.
// ----------------------------------------------------------------------------
module ole_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ole_pkg::VALUE_W-1:0]   rsp_removed_value,
  input logic [ole_pkg::STATUS_W-1:0]  rsp_status,
  input logic [ole_pkg::COUNT_W-1:0]   rsp_entry_count
);
  import ole_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // Go busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready held after an accepted item");

  // Report full only with a full store
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> (rsp_entry_count == COUNT_W'(DEPTH)))
    else $error("full status with free space");

  // Report empty only with an empty store
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_entry_count == '0))
    else $error("empty status with entries held");

  // Removed value only from a successful operation
  a_removed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_removed_value != '0) |-> (rsp_status == ST_OK))
    else $error("removed value on a failed operation");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_removed_value (rsp.removed_value),
  .rsp_status        (rsp.status),
  .rsp_entry_count   (rsp.entry_count)
);
